// ===== rtl/e2g_pkg.sv =====
// e2g_pkg: shared constants, register indexes, unit request/response types
// and the CORDIC arctangent table for the ECEF to geodetic core.
// No dependencies.
package e2g_pkg;

	localparam int DW         = 64;	// internal datapath width
	localparam int COORD_W    = 35;
	localparam int HGT_W      = 35;
	localparam int ANG_OUT_W  = 32;
	localparam int ITER_OUT_W = 4;
	localparam int LFRAC      = 24;	// fraction bits of lengths
	localparam int NSTEP      = 31;	// CORDIC micro-rotations
	localparam int STEP_W     = 5;
	localparam int RADIUS_W   = 33;
	localparam int ECC_W      = 28;
	localparam int THR_W      = 16;
	localparam int CFG_W      = 33;
	localparam int CFG_IDX_W  = 2;
	localparam int SH_W       = 6;

	localparam logic [SH_W-1:0] SH_KINV = 6'd32;
	localparam logic [SH_W-1:0] SH_Q30  = 6'd30;
	localparam logic [SH_W-1:0] SH_AE   = 6'd8;
	localparam logic [SH_W-1:0] SH_HGT  = 6'd6;

	localparam logic signed [DW-1:0] KINV32 = 64'sd2608131496;
	localparam logic signed [DW-1:0] KINV30 = 64'sd652032874;
	localparam logic signed [DW-1:0] ONE30  = 64'sd1073741824;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 33'd6378140000;
	localparam logic [ECC_W-1:0]    ECC_RST    = 28'd28752165;
	localparam logic [THR_W-1:0]    THR_RST    = 16'd684;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_ECC    = 2'd1,
		REG_THRESH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                 go;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic [SH_W-1:0]      sh;
	} mul_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [DW-1:0] res;
	} mul_rsp_t;

	typedef struct packed {
		logic                 go;
		logic                 rot;	// 1: rotation, 0: vectoring
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
	} cordic_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
	} cordic_rsp_t;

	typedef struct packed {
		logic          go;
		logic          sq;	// 1: square root of num, 0: num / den
		logic [DW-1:0] num;
		logic [DW-1:0] den;
	} rd_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] res;
	} rd_rsp_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_tab(input logic [STEP_W-1:0] i);
		logic [31:0] t;
		case (i)
			5'd0:  t = 32'd536870912;
			5'd1:  t = 32'd316933406;
			5'd2:  t = 32'd167458907;
			5'd3:  t = 32'd85004756;
			5'd4:  t = 32'd42667331;
			5'd5:  t = 32'd21354465;
			5'd6:  t = 32'd10679838;
			5'd7:  t = 32'd5340245;
			5'd8:  t = 32'd2670163;
			5'd9:  t = 32'd1335087;
			5'd10: t = 32'd667544;
			5'd11: t = 32'd333772;
			5'd12: t = 32'd166886;
			5'd13: t = 32'd83443;
			5'd14: t = 32'd41722;
			5'd15: t = 32'd20861;
			5'd16: t = 32'd10430;
			5'd17: t = 32'd5215;
			5'd18: t = 32'd2608;
			5'd19: t = 32'd1304;
			5'd20: t = 32'd652;
			5'd21: t = 32'd326;
			5'd22: t = 32'd163;
			5'd23: t = 32'd81;
			5'd24: t = 32'd41;
			5'd25: t = 32'd20;
			5'd26: t = 32'd10;
			5'd27: t = 32'd5;
			5'd28: t = 32'd3;
			5'd29: t = 32'd1;
			5'd30: t = 32'd1;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/e2g_in_if.sv =====
// e2g_in_if: position word channel (valid/ready plus X, Y, Z).
// Depends on e2g_pkg.
interface e2g_in_if import e2g_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_mm;
	logic signed [COORD_W-1:0] y_mm;
	logic signed [COORD_W-1:0] z_mm;

	modport source(output valid, output x_mm, output y_mm, output z_mm, input ready);
	modport sink(input valid, input x_mm, input y_mm, input z_mm, output ready);
endinterface

// ===== rtl/e2g_out_if.sv =====
// e2g_out_if: geodetic result word channel (valid/ready plus payload).
// Depends on e2g_pkg.
interface e2g_out_if import e2g_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [ANG_OUT_W-1:0]        longitude;
	logic signed [ANG_OUT_W-1:0] latitude;
	logic signed [HGT_W-1:0]     height_mm;
	logic                        converged;
	logic [ITER_OUT_W-1:0]       iterations_used;

	modport source(output valid, output longitude, output latitude, output height_mm,
		output converged, output iterations_used, input ready);
	modport sink(input valid, input longitude, input latitude, input height_mm,
		input converged, input iterations_used, output ready);
endinterface

// ===== rtl/ecef_to_geodetic_core.sv =====
// ecef_to_geodetic_core: top level, sequencer and result register.
// Depends on e2g_pkg, e2g_in_if, e2g_out_if, e2g_cordic, e2g_mul, e2g_rootdiv.
//
// Usage
//   pos  : sink channel, one word = X, Y, Z in signed millimetres.
//   geo  : source channel, one word = longitude, latitude, height, converged
//          flag and refinement pass count.
//   cfg  : write port (cfg_we, cfg_index, cfg_data); radius, e2, threshold.
//          Write only while no position word is in flight.
// Timing
//   One word at a time. pos.ready is high only while the sequencer is idle.
//   A word takes N refinement passes, N = 0..MAX_ITER. Each pass is dominated
//   by the 64-step bit-serial divider, the 32-step square root and two 31-step
//   CORDIC runs; every arithmetic step goes through one of three shared units
//   (CORDIC, 64x16 multiplier, root/divide) used strictly one at a time.
// Reset
//   arst_n clears the sequencer, unit handshakes and the result valid flag and
//   loads the ellipsoid registers with their defaults.
// Stall
//   A finished word waits in the result register; if geo.ready is low when the
//   next result is done, the sequencer holds until the register frees.
module ecef_to_geodetic_core import e2g_pkg::*; #(
	parameter int MAX_ITER   = 8,
	parameter int ANGLE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	e2g_in_if.sink               pos,
	e2g_out_if.source            geo
);

	localparam int AW   = ANGLE_BITS + 2;
	localparam int IT_W = $clog2(MAX_ITER + 1);
	localparam int UP   = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
	localparam int DN   = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;

	localparam logic signed [AW-1:0] HALF_A    = AW'(64'd1 << (ANGLE_BITS - 1));
	localparam logic signed [AW-1:0] QUARTER_A = AW'(64'd1 << (ANGLE_BITS - 2));
	localparam logic signed [AW-1:0] TQ_A      = AW'(64'd3 << (ANGLE_BITS - 2));
	localparam logic signed [DW-1:0] RND       = 64'sd1 <<< (LFRAC - 1);
	localparam logic signed [DW-1:0] HMAX      = (64'sd1 <<< (HGT_W - 1)) - 64'sd1;
	localparam logic signed [DW-1:0] HMIN      = -(64'sd1 <<< (HGT_W - 1));

	typedef enum logic [18:0] {
		ST_IDLE  = 19'h00001,
		ST_START = 19'h00002,
		ST_LON   = 19'h00004,
		ST_RAD   = 19'h00008,
		ST_RCHK  = 19'h00010,
		ST_AE    = 19'h00020,
		ST_LAT0  = 19'h00040,
		ST_CHECK = 19'h00080,
		ST_ROT   = 19'h00100,
		ST_S2    = 19'h00200,
		ST_P     = 19'h00400,
		ST_SQ    = 19'h00800,
		ST_DIV   = 19'h01000,
		ST_NUM   = 19'h02000,
		ST_VEC   = 19'h04000,
		ST_H1    = 19'h08000,
		ST_H2    = 19'h10000,
		ST_H3    = 19'h20000,
		ST_DONE  = 19'h40000
	} state_t;

	state_t state_q;

	// ellipsoid registers
	logic [RADIUS_W-1:0] radius_q;
	logic [ECC_W-1:0]    ecc_q;
	logic [THR_W-1:0]    thr_q;

	// working registers
	logic signed [COORD_W-1:0] x_q, y_q, z_q;
	logic signed [DW-1:0]      r_q, s_q, ae_q, h1_q, h2_q, h3_q;
	logic signed [AW-1:0]      b_q, old_q, lon_q;
	logic [IT_W-1:0]           it_q;
	logic                      conv_q, fin_q, hgt_q, neg_q;

	// unit requests
	logic                 mul_go_q, cor_go_q, cor_rot_q, rd_go_q, rd_sq_q;
	logic signed [DW-1:0] mul_a_q, mul_b_q, cor_x_q, cor_y_q;
	logic [SH_W-1:0]      mul_sh_q;
	logic [DW-1:0]        rd_num_q, rd_den_q;

	mul_req_t    mul_req;
	mul_rsp_t    mul_rsp;
	cordic_req_t cor_req;
	cordic_rsp_t cor_rsp;
	rd_req_t     rd_req;
	rd_rsp_t     rd_rsp;
	logic signed [AW-1:0] cor_ang;
	logic        mul_busy, cor_busy, rd_busy;

	// result register
	logic                        out_v_q;
	logic [ANG_OUT_W-1:0]        lon_out_q;
	logic signed [ANG_OUT_W-1:0] lat_out_q;
	logic signed [HGT_W-1:0]     hgt_out_q;
	logic                        conv_out_q;
	logic [ITER_OUT_W-1:0]       it_out_q;

	// combinational helpers
	logic signed [DW-1:0] xf, yf, zf, cy_abs, s_abs, num, h_sum, h_rnd, h_sh;
	logic [DW-1:0]        sq_in, w_fix;
	logic signed [AW:0]   ddiff;
	logic [AW:0]          dmag;
	logic                 big;
	logic signed [DW-1:0] bx;
	logic [DW-1:0]        lonm;
	logic signed [HGT_W-1:0] h_sat;

	assign xf     = DW'(x_q) <<< LFRAC;
	assign yf     = DW'(y_q) <<< LFRAC;
	assign zf     = DW'(z_q) <<< LFRAC;
	assign cy_abs = cor_rsp.y[DW-1] ? -cor_rsp.y : cor_rsp.y;
	assign s_abs  = s_q[DW-1] ? -s_q : s_q;
	// 1 - e2 sin^2 in Q30, clamped at zero, then moved up for the Q30 root
	assign sq_in  = (mul_rsp.res >= ONE30) ? '0 : DW'(ONE30 - mul_rsp.res) << 30;
	assign w_fix  = (rd_rsp.res == '0) ? DW'(1) : rd_rsp.res;
	assign num    = zf + mul_rsp.res;
	assign ddiff  = (AW+1)'(b_q) - (AW+1)'(old_q);
	assign dmag   = ddiff[AW] ? (AW+1)'(-ddiff) : (AW+1)'(ddiff);
	assign big    = dmag > (AW+1)'(thr_q);

	// height: R cos b + Z sin b - a*w, rounded half up to mm, saturated
	assign h_sum  = h1_q + h2_q - h3_q;
	assign h_rnd  = h_sum + RND;
	assign h_sh   = h_rnd >>> LFRAC;
	assign h_sat  = (h_sh > HMAX) ? HGT_W'(HMAX) :
	                (h_sh < HMIN) ? HGT_W'(HMIN) : HGT_W'(h_sh);
	assign bx     = DW'(b_q);
	assign lonm   = DW'(lon_q[ANGLE_BITS-1:0]);

	assign mul_req.go  = mul_go_q;
	assign mul_req.a   = mul_a_q;
	assign mul_req.b   = mul_b_q;
	assign mul_req.sh  = mul_sh_q;
	assign cor_req.go  = cor_go_q;
	assign cor_req.rot = cor_rot_q;
	assign cor_req.x   = cor_x_q;
	assign cor_req.y   = cor_y_q;
	assign rd_req.go   = rd_go_q;
	assign rd_req.sq   = rd_sq_q;
	assign rd_req.num  = rd_num_q;
	assign rd_req.den  = rd_den_q;

	e2g_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cor_req),
		.ang_in  (b_q),
		.rsp     (cor_rsp),
		.ang_out (cor_ang),
		.busy    (cor_busy)
	);

	e2g_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp),
		.busy   (mul_busy)
	);

	e2g_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rd_req),
		.rsp    (rd_rsp),
		.busy   (rd_busy)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			ecc_q    <= ECC_RST;
			thr_q    <= THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_ECC:    ecc_q    <= cfg_data[ECC_W-1:0];
				REG_THRESH: thr_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mul_go_q <= 1'b0;
			cor_go_q <= 1'b0;
			rd_go_q  <= 1'b0;
			out_v_q  <= 1'b0;
			it_q     <= '0;
			conv_q   <= 1'b0;
			fin_q    <= 1'b0;
			hgt_q    <= 1'b0;
			neg_q    <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			cor_go_q <= 1'b0;
			rd_go_q  <= 1'b0;
			if (geo.valid && geo.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pos.valid) begin
						x_q     <= pos.x_mm;
						y_q     <= pos.y_mm;
						z_q     <= pos.z_mm;
						it_q    <= '0;
						conv_q  <= 1'b1;
						old_q   <= '0;
						hgt_q   <= 1'b0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (y_q == '0) begin
						lon_q   <= x_q[COORD_W-1] ? HALF_A : '0;
						r_q     <= x_q[COORD_W-1] ? -xf : xf;
						state_q <= ST_RCHK;
					end else if (x_q == '0) begin
						lon_q   <= y_q[COORD_W-1] ? TQ_A : QUARTER_A;
						r_q     <= y_q[COORD_W-1] ? -yf : yf;
						state_q <= ST_RCHK;
					end else begin
						neg_q     <= x_q[COORD_W-1];
						cor_go_q  <= 1'b1;
						cor_rot_q <= 1'b0;
						cor_x_q   <= x_q[COORD_W-1] ? -xf : xf;
						cor_y_q   <= x_q[COORD_W-1] ? -yf : yf;
						state_q   <= ST_LON;
					end
				end
				ST_LON: begin
					if (cor_rsp.done) begin
						lon_q    <= neg_q ? HALF_A + cor_ang : cor_ang;
						mul_go_q <= 1'b1;
						mul_a_q  <= cor_rsp.x;
						mul_b_q  <= KINV32;
						mul_sh_q <= SH_KINV;
						state_q  <= ST_RAD;
					end
				end
				ST_RAD: begin
					if (mul_rsp.done) begin
						r_q     <= mul_rsp.res;
						state_q <= ST_RCHK;
					end
				end
				ST_RCHK: begin
					if (r_q <= 0) begin
						// on the polar axis: skip refinement
						r_q      <= '0;
						b_q      <= z_q[COORD_W-1] ? -QUARTER_A : QUARTER_A;
						s_q      <= z_q[COORD_W-1] ? -ONE30 : ONE30;
						hgt_q    <= 1'b1;
						mul_go_q <= 1'b1;
						mul_a_q  <= '0;
						mul_b_q  <= '0;
						mul_sh_q <= SH_Q30;
						state_q  <= ST_H1;
					end else begin
						mul_go_q <= 1'b1;
						mul_a_q  <= DW'(radius_q);
						mul_b_q  <= DW'(ecc_q);
						mul_sh_q <= SH_AE;
						state_q  <= ST_AE;
					end
				end
				ST_AE: begin
					if (mul_rsp.done) begin
						ae_q <= mul_rsp.res;
						if (z_q == '0) begin
							b_q     <= '0;
							state_q <= ST_CHECK;
						end else begin
							cor_go_q  <= 1'b1;
							cor_rot_q <= 1'b0;
							cor_x_q   <= r_q;
							cor_y_q   <= zf;
							state_q   <= ST_LAT0;
						end
					end
				end
				ST_LAT0, ST_VEC: begin
					if (cor_rsp.done) begin
						b_q     <= cor_ang;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cor_go_q  <= 1'b1;
					cor_rot_q <= 1'b1;
					cor_x_q   <= KINV30;
					cor_y_q   <= '0;
					state_q   <= ST_ROT;
					if (it_q < IT_W'(MAX_ITER) && big) begin
						old_q <= b_q;
						fin_q <= 1'b0;
					end else begin
						conv_q <= !big;
						fin_q  <= 1'b1;
					end
				end
				ST_ROT: begin
					if (cor_rsp.done) begin
						s_q      <= cor_rsp.y;
						mul_go_q <= 1'b1;
						mul_sh_q <= SH_Q30;
						if (fin_q) begin
							hgt_q   <= 1'b1;
							mul_a_q <= r_q;
							mul_b_q <= cor_rsp.x;
							state_q <= ST_H1;
						end else begin
							mul_a_q <= cy_abs;
							mul_b_q <= cy_abs;
							state_q <= ST_S2;
						end
					end
				end
				ST_S2: begin
					if (mul_rsp.done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= DW'(ecc_q);
						mul_b_q  <= mul_rsp.res;
						mul_sh_q <= SH_KINV;
						state_q  <= ST_P;
					end
				end
				ST_P: begin
					if (mul_rsp.done) begin
						rd_go_q  <= 1'b1;
						rd_sq_q  <= 1'b1;
						rd_num_q <= sq_in;
						rd_den_q <= '0;
						state_q  <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (rd_rsp.done) begin
						if (hgt_q) begin
							mul_go_q <= 1'b1;
							mul_a_q  <= DW'(radius_q);
							mul_b_q  <= rd_rsp.res;
							mul_sh_q <= SH_HGT;
							state_q  <= ST_H3;
						end else begin
							rd_go_q  <= 1'b1;
							rd_sq_q  <= 1'b0;
							rd_num_q <= DW'(s_abs) << 30;
							rd_den_q <= w_fix;
							state_q  <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (rd_rsp.done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= ae_q;
						mul_b_q  <= s_q[DW-1] ? -$signed(rd_rsp.res) : $signed(rd_rsp.res);
						mul_sh_q <= SH_Q30;
						state_q  <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (mul_rsp.done) begin
						it_q <= it_q + 1'b1;
						if (num == '0) begin
							b_q     <= '0;
							state_q <= ST_CHECK;
						end else begin
							cor_go_q  <= 1'b1;
							cor_rot_q <= 1'b0;
							cor_x_q   <= r_q;
							cor_y_q   <= num;
							state_q   <= ST_VEC;
						end
					end
				end
				ST_H1: begin
					if (mul_rsp.done) begin
						h1_q     <= mul_rsp.res;
						mul_go_q <= 1'b1;
						mul_a_q  <= zf;
						mul_b_q  <= s_q;
						mul_sh_q <= SH_Q30;
						state_q  <= ST_H2;
					end
				end
				ST_H2: begin
					if (mul_rsp.done) begin
						// reuse the weight sequence for sqrt(1 - e2 sin^2)
						h2_q     <= mul_rsp.res;
						mul_go_q <= 1'b1;
						mul_a_q  <= s_abs;
						mul_b_q  <= s_abs;
						mul_sh_q <= SH_Q30;
						state_q  <= ST_S2;
					end
				end
				ST_H3: begin
					if (mul_rsp.done) begin
						h3_q    <= mul_rsp.res;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_v_q || geo.ready) begin
						out_v_q    <= 1'b1;
						lon_out_q  <= ANG_OUT_W'((lonm >> DN) << UP);
						lat_out_q  <= ANG_OUT_W'((bx >>> DN) <<< UP);
						hgt_out_q  <= h_sat;
						conv_out_q <= conv_q;
						it_out_q   <= ITER_OUT_W'(it_q);
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pos.ready           = (state_q == ST_IDLE);
	assign geo.valid           = out_v_q;
	assign geo.longitude       = lon_out_q;
	assign geo.latitude        = lat_out_q;
	assign geo.height_mm       = hgt_out_q;
	assign geo.converged       = conv_out_q;
	assign geo.iterations_used = it_out_q;

	// shared units run strictly one at a time
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_busy, cor_busy, rd_busy}))
		else $error("more than one arithmetic unit busy");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		it_q <= IT_W'(MAX_ITER))
		else $error("pass counter beyond MAX_ITER");

	a_noconv_max: assert property (@(posedge clk) disable iff (!arst_n)
		geo.valid && !geo.converged |-> geo.iterations_used == ITER_OUT_W'(MAX_ITER))
		else $error("unconverged word before MAX_ITER passes");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		pos.valid && pos.ready |=> !pos.ready)
		else $error("input taken while a word is in flight");

endmodule

// ===== rtl/e2g_mul.sv =====
// e2g_mul: sequential signed multiplier, 64x16 bits per cycle, returning
// bits [sh+62:sh] of |a|*|b| with the sign applied. Depends on e2g_pkg.
module e2g_mul import e2g_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp,
	output logic     busy
);

	logic [DW-1:0]     ua_q, ub_q;
	logic [2*DW-1:0]   acc_q;
	logic              neg_q;
	logic [SH_W-1:0]   sh_q;
	logic [2:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic signed [DW-1:0] res_q;

	logic [DW+15:0]    pp;
	logic [2*DW-1:0]   acc_nxt;
	logic [2*DW-1:0]   shifted;
	logic [DW-1:0]     mag;

	assign pp      = ua_q * ub_q[15:0];
	assign acc_nxt = acc_q + ((2*DW)'(pp) << {cnt_q[1:0], 4'b0000});
	assign shifted = acc_q >> sh_q;
	assign mag     = {1'b0, shifted[DW-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				ua_q  <= req.a[DW-1] ? DW'(-req.a) : DW'(req.a);
				ub_q  <= req.b[DW-1] ? DW'(-req.b) : DW'(req.b);
				neg_q <= req.a[DW-1] ^ req.b[DW-1];
				sh_q  <= req.sh;
				acc_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == 3'd4) begin
					// last cycle: window and sign
					res_q  <= neg_q ? -$signed(mag) : $signed(mag);
					done_q <= 1'b1;
					run_q  <= 1'b0;
				end else begin
					acc_q <= acc_nxt;
					ub_q  <= ub_q >> 16;
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;
	assign busy     = run_q;

endmodule

// ===== rtl/e2g_rootdiv.sv =====
// e2g_rootdiv: bit-serial unit for floor square root (32 steps) and
// unsigned 64-bit division (64 steps). Depends on e2g_pkg.
module e2g_rootdiv import e2g_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  rd_req_t req,
	output rd_rsp_t rsp,
	output logic    busy
);

	logic [DW-1:0] v_q;	// sqrt remainder / dividend-quotient
	logic [DW-1:0] r_q;	// sqrt root / division remainder
	logic [DW-1:0] bit_q;	// sqrt test bit / divisor
	logic          sq_q;
	logic [6:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW-1:0] res_q;

	logic [DW-1:0] trial;
	logic          fits;
	logic [DW:0]   rem_sh;
	logic          dfit;
	logic [6:0]    last;

	assign trial  = r_q + bit_q;
	assign fits   = v_q >= trial;
	assign rem_sh = {r_q, v_q[DW-1]};
	assign dfit   = rem_sh >= {1'b0, bit_q};
	assign last   = sq_q ? 7'd31 : 7'd63;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				sq_q  <= req.sq;
				v_q   <= req.num;
				r_q   <= '0;
				bit_q <= req.sq ? (DW'(1) << 62) : req.den;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (sq_q) begin
					if (fits) begin
						v_q <= v_q - trial;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					if (dfit) begin
						r_q <= DW'(rem_sh - {1'b0, bit_q});
					end else begin
						r_q <= rem_sh[DW-1:0];
					end
					v_q <= {v_q[DW-2:0], dfit};
				end
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (run_q && cnt_q == last) begin
				if (sq_q) begin
					res_q <= fits ? (r_q >> 1) + bit_q : r_q >> 1;
				end else begin
					res_q <= {v_q[DW-2:0], dfit};
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;
	assign busy     = run_q;

endmodule

// ===== rtl/e2g_cordic.sv =====
// e2g_cordic: 31-step CORDIC, one micro-rotation per cycle, in vectoring
// (angle of x,y) or rotation (cos/sin) mode. Depends on e2g_pkg.
module e2g_cordic import e2g_pkg::*; #(
	parameter int ANGLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cordic_req_t                   req,
	input  logic signed [ANGLE_BITS+1:0]  ang_in,
	output cordic_rsp_t                   rsp,
	output logic signed [ANGLE_BITS+1:0]  ang_out,
	output logic                          busy
);

	localparam int AW = ANGLE_BITS + 2;
	localparam int UP = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
	localparam int DN = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;

	logic signed [DW-1:0] x_q, y_q;
	logic signed [AW-1:0] ang_q;
	logic [STEP_W-1:0]    i_q;
	logic                 rot_q;
	logic                 run_q;
	logic                 done_q;

	logic [DW-1:0]        t64;
	logic signed [AW-1:0] t;
	logic signed [DW-1:0] dx, dy;
	logic                 dir;

	assign t64 = ((DW'(atan_tab(i_q))) << UP) >> DN;
	assign t   = $signed(t64[AW-1:0]);
	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign dir = rot_q ? !ang_q[AW-1] : (y_q > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				x_q   <= req.x;
				y_q   <= req.y;
				ang_q <= req.rot ? ang_in : '0;
				rot_q <= req.rot;
				i_q   <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (rot_q == dir) begin
					// rotation with ang >= 0, or vectoring with y <= 0
					x_q   <= x_q - dx;
					y_q   <= y_q + dy;
					ang_q <= rot_q ? ang_q - t : ang_q - t;
				end else begin
					x_q   <= x_q + dx;
					y_q   <= y_q - dy;
					ang_q <= ang_q + t;
				end
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(NSTEP - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign ang_out  = ang_q;
	assign busy     = run_q;

endmodule
